// ===== design/swtr_pkg.sv =====
package swtr_pkg;

   localparam logic [9:0] MAX_PAYLOAD = 10'd1000;
   localparam int unsigned TYPE_SHIFT = 28;
   localparam int unsigned SEQ_W = 28;
   localparam int unsigned LEN_W = 10;

   // Both internal queues share one depth
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_LISTEN = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_PACKET = 2'd2;

   localparam logic [3:0] PKT_SYN     = 4'd0;
   localparam logic [3:0] PKT_SYN_ACK = 4'd1;
   localparam logic [3:0] PKT_FIN     = 4'd2;
   localparam logic [3:0] PKT_ACK     = 4'd4;
   localparam logic [3:0] PKT_DATA    = 4'd5;

   localparam logic [2:0] CODE_CLOSED    = 3'd0;
   localparam logic [2:0] CODE_AWAIT_SYN = 3'd1;
   localparam logic [2:0] CODE_AWAIT_ACK = 3'd2;
   localparam logic [2:0] CODE_CONNECTED = 3'd3;
   localparam logic [2:0] CODE_WAIT_DATA = 3'd4;
   localparam logic [2:0] CODE_FIN_RCVD  = 3'd5;

   typedef enum logic [5:0] {
      MODE_CLOSED    = 6'b000001,
      MODE_AWAIT_SYN = 6'b000010,
      MODE_AWAIT_ACK = 6'b000100,
      MODE_CONNECTED = 6'b001000,
      MODE_WAIT_DATA = 6'b010000,
      MODE_FIN_RCVD  = 6'b100000
   } mode_type;

   typedef enum logic [2:0] {
      K_IGNORE = 3'd0,
      K_LISTEN = 3'd1,
      K_READ   = 3'd2,
      K_SYN    = 3'd3,
      K_ACK    = 3'd4,
      K_FIN    = 3'd5,
      K_DATA   = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [SEQ_W-1:0]  seq;
      logic [LEN_W-1:0]  len;
   } cmd_type;

   typedef struct packed {
      logic        tx_valid;
      logic [31:0] tx_header;
      logic        deliver;
      logic        connected_event;
      logic        fin_seen;
      logic [2:0]  link_state;
   } rsp_type;

   function automatic logic [2:0] mode_code(input mode_type mode);
      logic [2:0] code;
      unique case (mode)
         MODE_CLOSED:    code = CODE_CLOSED;
         MODE_AWAIT_SYN: code = CODE_AWAIT_SYN;
         MODE_AWAIT_ACK: code = CODE_AWAIT_ACK;
         MODE_CONNECTED: code = CODE_CONNECTED;
         MODE_WAIT_DATA: code = CODE_WAIT_DATA;
         MODE_FIN_RCVD:  code = CODE_FIN_RCVD;
         default:        code = CODE_CLOSED;
      endcase
      return code;
   endfunction

endpackage

// ===== design/swtr_front.sv =====
module swtr_front (
   input  logic [1:0]              action,
   input  logic [31:0]             rx_header,
   input  logic [9:0]              payload_length,
   output swtr_pkg::cmd_type       cmd
);

   logic [3:0] pkt_type;

   assign pkt_type = rx_header[31:swtr_pkg::TYPE_SHIFT];

   always_comb begin
      cmd.seq = rx_header[swtr_pkg::SEQ_W-1:0];
      // clamp oversized payloads
      cmd.len = (payload_length > swtr_pkg::MAX_PAYLOAD) ? swtr_pkg::MAX_PAYLOAD
                                                        : payload_length;
      cmd.kind = swtr_pkg::K_IGNORE;
      unique case (action)
         swtr_pkg::ACT_LISTEN: cmd.kind = swtr_pkg::K_LISTEN;
         swtr_pkg::ACT_READ:   cmd.kind = swtr_pkg::K_READ;
         swtr_pkg::ACT_PACKET: begin
            unique case (pkt_type)
               swtr_pkg::PKT_SYN:  cmd.kind = swtr_pkg::K_SYN;
               swtr_pkg::PKT_ACK:  cmd.kind = swtr_pkg::K_ACK;
               swtr_pkg::PKT_FIN:  cmd.kind = swtr_pkg::K_FIN;
               swtr_pkg::PKT_DATA: cmd.kind = swtr_pkg::K_DATA;
               default:            cmd.kind = swtr_pkg::K_IGNORE;
            endcase
         end
         default: cmd.kind = swtr_pkg::K_IGNORE;
      endcase
   end

endmodule

// ===== design/swtr_cmd_queue.sv =====
module swtr_cmd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  swtr_pkg::cmd_type       push_cmd,
   output logic                    full,
   input  logic                    pop_valid,
   output swtr_pkg::cmd_type       pop_cmd,
   output logic                    empty
);

   localparam logic [swtr_pkg::QCNT_W-1:0] DEPTH_CNT =
      swtr_pkg::QCNT_W'(swtr_pkg::QUEUE_DEPTH);
   localparam logic [swtr_pkg::QPTR_W-1:0] LAST_PTR =
      swtr_pkg::QPTR_W'(swtr_pkg::QUEUE_DEPTH - 1);

   swtr_pkg::cmd_type                 slot_ff [swtr_pkg::QUEUE_DEPTH];
   logic [swtr_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [swtr_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [swtr_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                              do_push, do_pop;

   assign full    = (cnt_ff == DEPTH_CNT);
   assign empty   = (cnt_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop_valid && !empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/swtr_back.sv =====
module swtr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  swtr_pkg::cmd_type       cmd,
   input  logic                    cmd_empty,
   output logic                    cmd_pop,
   output swtr_pkg::rsp_type       rsp,
   output logic                    rsp_empty,
   input  logic                    rsp_pop
);

   localparam logic [swtr_pkg::QCNT_W-1:0] DEPTH_CNT =
      swtr_pkg::QCNT_W'(swtr_pkg::QUEUE_DEPTH);
   localparam logic [swtr_pkg::QPTR_W-1:0] LAST_PTR =
      swtr_pkg::QPTR_W'(swtr_pkg::QUEUE_DEPTH - 1);

   swtr_pkg::mode_type                mode_ff, mode_in;
   logic [31:0]                       expected_ff, expected_in;

   swtr_pkg::rsp_type                 slot_ff [swtr_pkg::QUEUE_DEPTH];
   logic [swtr_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [swtr_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [swtr_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;

   logic                              exec;
   logic                              do_pop;
   logic [31:0]                       seq_ext;
   logic [31:0]                       addend;
   logic [31:0]                       sum;
   logic                              seq_match;
   logic                              seq_older;
   swtr_pkg::rsp_type                 result;
   logic [3:0]                        tx_type;

   // execute when a command is waiting and the result buffer has room, counting this cycle's pop
   assign do_pop    = rsp_pop && (cnt_ff != '0);
   assign exec      = !cmd_empty && ((cnt_ff != DEPTH_CNT) || do_pop);
   assign cmd_pop   = exec;
   assign rsp_empty = (cnt_ff == '0);
   assign rsp       = slot_ff[rd_ptr_ff];

   assign seq_ext   = {{(32 - swtr_pkg::SEQ_W){1'b0}}, cmd.seq};
   assign addend    = (cmd.kind == swtr_pkg::K_DATA)
                      ? {{(32 - swtr_pkg::LEN_W){1'b0}}, cmd.len} : 32'd1;
   assign sum       = seq_ext + addend;
   assign seq_match = (seq_ext == expected_ff);
   assign seq_older = (seq_ext < expected_ff);

   always_comb begin
      mode_in     = mode_ff;
      expected_in = expected_ff;
      result      = '0;
      tx_type     = swtr_pkg::PKT_ACK;
      case (cmd.kind)
         swtr_pkg::K_LISTEN: mode_in = swtr_pkg::MODE_AWAIT_SYN;
         swtr_pkg::K_READ: begin
            if (mode_ff == swtr_pkg::MODE_CONNECTED || mode_ff == swtr_pkg::MODE_WAIT_DATA) begin
               mode_in = swtr_pkg::MODE_WAIT_DATA;
            end
         end
         swtr_pkg::K_SYN: begin
            if (mode_ff == swtr_pkg::MODE_AWAIT_SYN && seq_match) begin
               expected_in     = sum;
               result.tx_valid = 1'b1;
               tx_type         = swtr_pkg::PKT_SYN_ACK;
               mode_in         = swtr_pkg::MODE_AWAIT_ACK;
            end
         end
         swtr_pkg::K_ACK: begin
            if (mode_ff == swtr_pkg::MODE_AWAIT_ACK && seq_match) begin
               result.connected_event = 1'b1;
               mode_in                = swtr_pkg::MODE_CONNECTED;
            end
         end
         swtr_pkg::K_FIN: begin
            if (mode_ff == swtr_pkg::MODE_WAIT_DATA) begin
               result.fin_seen = 1'b1;
               mode_in         = swtr_pkg::MODE_FIN_RCVD;
            end
         end
         swtr_pkg::K_DATA: begin
            if (mode_ff == swtr_pkg::MODE_WAIT_DATA) begin
               if (seq_match) begin
                  expected_in     = sum;
                  result.deliver  = 1'b1;
                  result.tx_valid = 1'b1;
               end else if (seq_older) begin
                  // duplicate: re-acknowledge only
                  result.tx_valid = 1'b1;
               end
            end
         end
         default: ;
      endcase
      result.tx_header  = result.tx_valid
                          ? (sum | {tx_type, {swtr_pkg::TYPE_SHIFT{1'b0}}}) : 32'd0;
      result.link_state = swtr_pkg::mode_code(mode_in);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (exec) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (exec && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !exec) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= swtr_pkg::MODE_CLOSED;
         expected_ff <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         if (exec) begin
            mode_ff     <= mode_in;
            expected_ff <= expected_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         slot_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

// ===== design/stop_and_wait_transport_receiver.sv =====
// Stop-and-wait transport receiver, server side.
// Input channel: drive req_action, req_rx_header and req_payload_length
// with push high; the request is taken at a clock edge where full is low.
// Every request produces exactly one result, in request order.
// Result channel: while empty is low the oldest result is on the rsp_
// ports; raise pop to take it.
// A front decoder classifies each request into a two-entry command
// queue; the back end applies it to the link state (one
// 32-bit compare pair and one 32-bit add) and writes a two-entry result
// queue.
// A taken request waits in the command queue; the back end registers its
// result into the result queue, from which pop takes it.
// Throughput: one request per cycle sustained while pop keeps up.
// When the consumer stalls, the result queue fills, then the command
// queue, and full rises after four outstanding results.
// Reset (synchronous, active high) empties both queues, sets the link to
// closed and clears the expected sequence.
module stop_and_wait_transport_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_rx_header,
   input  logic [9:0]  req_payload_length,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_tx_valid,
   output logic [31:0] rsp_tx_header,
   output logic        rsp_deliver,
   output logic        rsp_connected_event,
   output logic        rsp_fin_seen,
   output logic [2:0]  rsp_link_state
);

   swtr_pkg::cmd_type front_cmd;
   swtr_pkg::cmd_type back_cmd;
   swtr_pkg::rsp_type rsp;
   logic              cmd_empty;
   logic              cmd_pop;

   swtr_front u_front (
      .action         (req_action),
      .rx_header      (req_rx_header),
      .payload_length (req_payload_length),
      .cmd            (front_cmd)
   );

   swtr_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push),
      .push_cmd   (front_cmd),
      .full       (full),
      .pop_valid  (cmd_pop),
      .pop_cmd    (back_cmd),
      .empty      (cmd_empty)
   );

   swtr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   assign rsp_tx_valid        = rsp.tx_valid;
   assign rsp_tx_header       = rsp.tx_header;
   assign rsp_deliver         = rsp.deliver;
   assign rsp_connected_event = rsp.connected_event;
   assign rsp_fin_seen        = rsp.fin_seen;
   assign rsp_link_state      = rsp.link_state;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // action code three, ignored by the block
   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int NUM_ROWS = 25;
   localparam int RANDOM_ITEMS = 1875;
   localparam int CALM_TAIL = 250;
   localparam int DRAIN_EVERY = 700;
   localparam int LONG_HOLD = 200;
   localparam int STALL_LIMIT = 3000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [1:0]        act;
      logic [31:0]       hdr;
      logic [9:0]        len;
      logic              fixed;
      swtr_pkg::rsp_type want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_action = '0;
   logic [31:0] req_rx_header = '0;
   logic [9:0]  req_payload_length = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_tx_valid;
   logic [31:0] rsp_tx_header;
   logic        rsp_deliver;
   logic        rsp_connected_event;
   logic        rsp_fin_seen;
   logic [2:0]  rsp_link_state;

   // predicted link state
   logic [2:0]  link_code = swtr_pkg::CODE_CLOSED;
   logic [31:0] next_seq = '0;
   logic [31:0] ack_seq = '0;

   swtr_pkg::rsp_type link_results_due [$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          stalled_cycles = 0;
   bit          calm = 1'b0;
   bit          held = 1'b0;

   // directed requests; the expected result is typed in only where fixed is set
   row_type plan [NUM_ROWS] = '{
      '{swtr_pkg::ACT_READ,   32'h0000_0000, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_CLOSED}},
      '{swtr_pkg::ACT_PACKET, 32'h0000_0000, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_CLOSED}},
      '{ACT_NONE,             32'hFFFF_FFFF, 10'd1023, 1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_CLOSED}},
      '{swtr_pkg::ACT_LISTEN, 32'hFFFF_FFFF, 10'd1023, 1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_AWAIT_SYN}},
      '{swtr_pkg::ACT_PACKET, 32'h0000_0005, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_AWAIT_SYN}},
      '{swtr_pkg::ACT_PACKET, 32'hF000_0000, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_AWAIT_SYN}},
      '{swtr_pkg::ACT_PACKET, 32'h0000_0000, 10'd0,    1'b1,
        '{1'b1, 32'h1000_0001, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_AWAIT_ACK}},
      '{swtr_pkg::ACT_PACKET, 32'h4000_0000, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_AWAIT_ACK}},
      '{swtr_pkg::ACT_PACKET, 32'h4000_0001, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b1, 1'b0, swtr_pkg::CODE_CONNECTED}},
      '{swtr_pkg::ACT_PACKET, 32'h5000_0001, 10'd7,    1'b0, '0},
      '{swtr_pkg::ACT_READ,   32'h0000_0000, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_WAIT_DATA}},
      '{swtr_pkg::ACT_PACKET, 32'h5000_0001, 10'd0,    1'b1,
        '{1'b1, 32'h4000_0001, 1'b1, 1'b0, 1'b0, swtr_pkg::CODE_WAIT_DATA}},
      '{swtr_pkg::ACT_PACKET, 32'h5000_0001, 10'd1023, 1'b1,
        '{1'b1, 32'h4000_03E9, 1'b1, 1'b0, 1'b0, swtr_pkg::CODE_WAIT_DATA}},
      '{swtr_pkg::ACT_PACKET, 32'h5000_0000, 10'd5,    1'b1,
        '{1'b1, 32'h4000_0005, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_WAIT_DATA}},
      '{swtr_pkg::ACT_PACKET, 32'h5FFF_FFFF, 10'd1000, 1'b0, '0},
      '{swtr_pkg::ACT_PACKET, 32'h5000_03E9, 10'd1000, 1'b0, '0},
      '{swtr_pkg::ACT_PACKET, 32'h1000_07D1, 10'd3,    1'b0, '0},
      '{swtr_pkg::ACT_PACKET, 32'h3000_07D1, 10'd3,    1'b0, '0},
      '{swtr_pkg::ACT_READ,   32'h0000_0000, 10'd0,    1'b0, '0},
      '{swtr_pkg::ACT_PACKET, 32'h2000_0000, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b1, swtr_pkg::CODE_FIN_RCVD}},
      '{swtr_pkg::ACT_PACKET, 32'h5000_07D1, 10'd1,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_FIN_RCVD}},
      '{swtr_pkg::ACT_READ,   32'h0000_0000, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_FIN_RCVD}},
      '{swtr_pkg::ACT_LISTEN, 32'h0000_0000, 10'd0,    1'b1,
        '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, swtr_pkg::CODE_AWAIT_SYN}},
      '{swtr_pkg::ACT_PACKET, 32'h0000_07D1, 10'd0,    1'b0, '0},
      '{swtr_pkg::ACT_PACKET, 32'h4000_07D2, 10'd0,    1'b0, '0}
   };

   stop_and_wait_transport_receiver u_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_action          (req_action),
      .req_rx_header       (req_rx_header),
      .req_payload_length  (req_payload_length),
      .empty               (empty),
      .pop                 (pop),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_header       (rsp_tx_header),
      .rsp_deliver         (rsp_deliver),
      .rsp_connected_event (rsp_connected_event),
      .rsp_fin_seen        (rsp_fin_seen),
      .rsp_link_state      (rsp_link_state)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic swtr_pkg::rsp_type advance_link(input logic [1:0] act,
                                                      input logic [31:0] hdr,
                                                      input logic [9:0] len);
      logic [3:0]        ptype;
      logic [31:0]       seq;
      logic [31:0]       bytes;
      swtr_pkg::rsp_type r;
      ptype = hdr[31:28];
      seq = {4'd0, hdr[27:0]};
      bytes = {22'd0, (len > swtr_pkg::MAX_PAYLOAD) ? swtr_pkg::MAX_PAYLOAD : len};
      r = '0;
      case (act)
         swtr_pkg::ACT_LISTEN: link_code = swtr_pkg::CODE_AWAIT_SYN;
         swtr_pkg::ACT_READ: begin
            if (link_code == swtr_pkg::CODE_CONNECTED || link_code == swtr_pkg::CODE_WAIT_DATA)
               link_code = swtr_pkg::CODE_WAIT_DATA;
         end
         swtr_pkg::ACT_PACKET: begin
            case (link_code)
               swtr_pkg::CODE_AWAIT_SYN: begin
                  if (ptype == swtr_pkg::PKT_SYN && seq == next_seq) begin
                     ack_seq = seq + 32'd1;
                     next_seq = ack_seq;
                     r.tx_valid = 1'b1;
                     r.tx_header = {swtr_pkg::PKT_SYN_ACK, 28'd0} | ack_seq;
                     link_code = swtr_pkg::CODE_AWAIT_ACK;
                  end
               end
               swtr_pkg::CODE_AWAIT_ACK: begin
                  if (ptype == swtr_pkg::PKT_ACK && seq == next_seq) begin
                     ack_seq = seq + 32'd1;
                     r.connected_event = 1'b1;
                     link_code = swtr_pkg::CODE_CONNECTED;
                  end
               end
               swtr_pkg::CODE_WAIT_DATA: begin
                  if (ptype == swtr_pkg::PKT_FIN) begin
                     r.fin_seen = 1'b1;
                     link_code = swtr_pkg::CODE_FIN_RCVD;
                  end else if (ptype == swtr_pkg::PKT_DATA && seq <= next_seq) begin
                     // in order: deliver and advance; older: re-acknowledge only
                     r.deliver = (seq == next_seq);
                     ack_seq = seq + bytes;
                     if (r.deliver)
                        next_seq = ack_seq;
                     r.tx_valid = 1'b1;
                     r.tx_header = {swtr_pkg::PKT_ACK, 28'd0} | ack_seq;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.link_state = link_code;
      return r;
   endfunction

   // mostly well-formed sessions with random content, some noise and broken sequences
   task automatic pick_request(output logic [1:0] act, output logic [31:0] hdr,
                               output logic [9:0] len);
      int unsigned roll;
      logic [27:0] seq;
      roll = $urandom_range(99, 0);
      seq = next_seq[27:0];
      len = ($urandom_range(9, 0) == 0) ? 10'($urandom_range(1023, 1001))
                                         : 10'($urandom_range(1000, 0));
      act = swtr_pkg::ACT_PACKET;
      hdr = {swtr_pkg::PKT_DATA, seq};
      if (roll < 12) begin
         act = 2'($urandom_range(3, 0));
         hdr = $urandom;
         len = 10'($urandom_range(1023, 0));
      end else begin
         case (link_code)
            swtr_pkg::CODE_AWAIT_SYN: begin
               if (roll < 85)
                  hdr = {swtr_pkg::PKT_SYN, seq};
               else if (roll < 92)
                  hdr = {swtr_pkg::PKT_SYN, seq + 28'($urandom_range(5, 1))};
               else
                  hdr = {4'($urandom_range(15, 0)), seq};
            end
            swtr_pkg::CODE_AWAIT_ACK: begin
               if (roll < 85)
                  hdr = {swtr_pkg::PKT_ACK, seq};
               else if (roll < 92)
                  hdr = {swtr_pkg::PKT_ACK, seq - 28'($urandom_range(1, 0))};
               else
                  hdr = {4'($urandom_range(15, 0)), seq};
            end
            swtr_pkg::CODE_CONNECTED: begin
               if (roll < 90)
                  act = swtr_pkg::ACT_READ;
            end
            swtr_pkg::CODE_WAIT_DATA: begin
               if (roll < 60) begin
                  hdr = {swtr_pkg::PKT_DATA, seq};
               end else if (roll < 72) begin
                  if (next_seq != 0)
                     hdr = {swtr_pkg::PKT_DATA, 28'($urandom_range(next_seq - 1, 0))};
               end else if (roll < 78) begin
                  hdr = {swtr_pkg::PKT_DATA, seq + 28'($urandom_range(1000, 1))};
               end else if (roll < 83) begin
                  hdr = {swtr_pkg::PKT_FIN, 28'($urandom)};
               end else if (roll < 87) begin
                  act = swtr_pkg::ACT_READ;
               end else if (roll < 90) begin
                  act = swtr_pkg::ACT_LISTEN;
               end else begin
                  hdr = {4'($urandom_range(15, 0)), seq};
               end
            end
            default: begin
               if (roll < 90)
                  act = swtr_pkg::ACT_LISTEN;
            end
         endcase
      end
   endtask

   task automatic send_request(input logic [1:0] act, input logic [31:0] hdr,
                               input logic [9:0] len, input logic fixed,
                               input swtr_pkg::rsp_type want,
                               output swtr_pkg::rsp_type predicted);
      req_action <= act;
      req_rx_header <= hdr;
      req_payload_length <= len;
      push <= 1'b1;
      do @(posedge clock); while (full !== 1'b0);
      predicted = advance_link(act, hdr, len);
      link_results_due.push_back(fixed ? want : predicted);
   endtask

   task automatic hold_sender(input bit drain);
      if (drain) begin
         push <= 1'b0;
         do @(posedge clock); while (link_results_due.size() != 0);
      end else if (!calm && $urandom_range(4, 0) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(16, 1)) @(posedge clock);
      end
   endtask

   initial begin
      logic [1:0]        act;
      logic [31:0]       hdr;
      logic [9:0]        len;
      swtr_pkg::rsp_type predicted;
      int                counted;
      int                next_drain;
      counted = 0;
      next_drain = DRAIN_EVERY;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_ROWS; i++) begin
         send_request(plan[i].act, plan[i].hdr, plan[i].len, plan[i].fixed, plan[i].want,
                      predicted);
         hold_sender(1'b0);
      end
      while (counted < RANDOM_ITEMS) begin
         pick_request(act, hdr, len);
         send_request(act, hdr, len, 1'b0, '0, predicted);
         counted++;
         calm = (counted >= RANDOM_ITEMS - CALM_TAIL);
         if (counted >= next_drain) begin
            next_drain += DRAIN_EVERY;
            hold_sender(1'b1);
         end else begin
            hold_sender(1'b0);
         end
      end
      push <= 1'b0;
      while (link_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (!held && results_seen >= 300) begin
            // hold off long enough for the block to fill and stall its input
            held = 1'b1;
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(3, 0) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            repeat ($urandom_range(32, 1)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      swtr_pkg::rsp_type want;
      swtr_pkg::rsp_type got;
      if (!reset && pop && !empty) begin
         got = '{rsp_tx_valid, rsp_tx_header, rsp_deliver, rsp_connected_event,
                 rsp_fin_seen, rsp_link_state};
         results_seen++;
         if (link_results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d arrived with none expected: tx=%0b hdr=%h state=%0d",
                        results_seen, got.tx_valid, got.tx_header, got.link_state);
         end else begin
            want = link_results_due.pop_front();
            if (got.tx_valid !== want.tx_valid || got.tx_header !== want.tx_header ||
                got.deliver !== want.deliver ||
                got.connected_event !== want.connected_event ||
                got.fin_seen !== want.fin_seen || got.link_state !== want.link_state) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"result %0d mismatch: expected tx=%0b hdr=%h dlv=%0b conn=%0b ",
                            "fin=%0b state=%0d, actual tx=%0b hdr=%h dlv=%0b conn=%0b ",
                            "fin=%0b state=%0d"},
                           results_seen, want.tx_valid, want.tx_header, want.deliver,
                           want.connected_event, want.fin_seen, want.link_state,
                           got.tx_valid, got.tx_header, got.deliver,
                           got.connected_event, got.fin_seen, got.link_state);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

endmodule
